### rtl/rbst_pkg.sv
package rbst_pkg;

   // coordinate format
   localparam int COORD_W = 32;
   localparam int FRAC_BITS_DEF = 16;

   // register map
   localparam int NUM_REGS = 6;
   localparam int ADDR_W = 5;
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type entry_dist;
      coord_type hit_pos_x;
      coord_type hit_pos_y;
      coord_type hit_pos_z;
   } rsp_type;

   // per-axis interval handed from a lane to the merge stage
   typedef struct packed {
      coord_type t_near;
      coord_type t_far;
   } slab_type;

endpackage

### rtl/rbst_div.sv
module rbst_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   // one quotient bit per stage, restoring
   logic [DEN_W-1:0] rem_ff [1:NUM_W-1];
   logic [NUM_W-1:0] num_ff [1:NUM_W-1];
   logic [NUM_W-1:0] quo_ff [1:NUM_W];
   logic [DEN_W-1:0] den_ff [1:NUM_W-1];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] num_prev;
      logic [NUM_W-1:0] quo_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W+1:0] diff;
      logic [DEN_W-1:0] rem_in;
      logic             bit_in;

      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = num;
         assign quo_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[s];
         assign num_prev = num_ff[s];
         assign quo_prev = quo_ff[s];
         assign den_prev = den_ff[s];
      end

      // shift in next numerator bit, trial subtract
      always_comb begin
         rem_sh = {rem_prev, num_prev[NUM_W-1]};
         diff   = {1'b0, rem_sh} - {2'b00, den_prev};
         bit_in = ~diff[DEN_W+1];
         rem_in = bit_in ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s+1] <= {quo_prev[NUM_W-2:0], bit_in};
         end
      end

      // remainder, numerator and divisor only feed later stages
      if (s < NUM_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1] <= rem_in;
               num_ff[s+1] <= {num_prev[NUM_W-2:0], 1'b0};
               den_ff[s+1] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[NUM_W];

endmodule

### rtl/rbst_lane.sv
module rbst_lane #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  rbst_pkg::coord_type box_lo,
   input  rbst_pkg::coord_type box_hi,
   input  rbst_pkg::coord_type org,
   input  rbst_pkg::coord_type dir,
   output rbst_pkg::slab_type  slab
);

   localparam int W = rbst_pkg::COORD_W;
   localparam int NUM_W = W + 1 + FRAC_BITS;
   localparam rbst_pkg::coord_type CMAX = {1'b0, {(W-1){1'b1}}};
   localparam rbst_pkg::coord_type CMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [NUM_W-1:0] QMAX_POS = {{(FRAC_BITS+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NUM_W-1:0] QMAX_NEG = {{(FRAC_BITS+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic dir_zero;
      logic near_pos;
      logic far_neg;
      logic neg_near;
      logic neg_far;
   } flags_type;

   logic signed [W:0] diff_near, diff_far;
   logic [W:0]        mag_near, mag_far;
   logic              dir_neg;
   rbst_pkg::coord_type near_p, far_p;
   flags_type         flags_in;

   logic [NUM_W-1:0]  num_near_ff, num_far_ff;
   logic [W-1:0]      den_ff;
   flags_type         flags_ff [0:NUM_W];
   logic [NUM_W-1:0]  quo_near, quo_far;
   rbst_pkg::slab_type slab_in, slab_ff;

   // plane select and numerators
   always_comb begin
      dir_neg   = dir[W-1];
      near_p    = dir_neg ? box_hi : box_lo;
      far_p     = dir_neg ? box_lo : box_hi;
      diff_near = {near_p[W-1], near_p} - {org[W-1], org};
      diff_far  = {far_p[W-1], far_p} - {org[W-1], org};
      mag_near  = diff_near[W] ? (~diff_near + (W+1)'(1)) : diff_near;
      mag_far   = diff_far[W] ? (~diff_far + (W+1)'(1)) : diff_far;
      flags_in.dir_zero = (dir == '0);
      flags_in.near_pos = ~diff_near[W] && (diff_near != '0);
      flags_in.far_neg  = diff_far[W];
      flags_in.neg_near = diff_near[W] ^ dir_neg;
      flags_in.neg_far  = diff_far[W] ^ dir_neg;
   end

   // input stage
   always_ff @(posedge clock) begin
      if (en) begin
         num_near_ff <= {mag_near, {FRAC_BITS{1'b0}}};
         num_far_ff  <= {mag_far, {FRAC_BITS{1'b0}}};
         den_ff      <= dir_neg ? (~dir + W'(1)) : dir;
         flags_ff[0] <= flags_in;
      end
   end

   rbst_div #(.NUM_W(NUM_W), .DEN_W(W)) u_div_near (
      .clock (clock),
      .en    (en),
      .num   (num_near_ff),
      .den   (den_ff),
      .quo   (quo_near)
   );

   rbst_div #(.NUM_W(NUM_W), .DEN_W(W)) u_div_far (
      .clock (clock),
      .en    (en),
      .num   (num_far_ff),
      .den   (den_ff),
      .quo   (quo_far)
   );

   // flags ride along with the divider
   for (genvar s = 0; s < NUM_W; s++) begin : g_flags
      always_ff @(posedge clock) begin
         if (en) begin
            flags_ff[s+1] <= flags_ff[s];
         end
      end
   end

   function automatic rbst_pkg::coord_type sat_quo(input logic [NUM_W-1:0] q,
                                                   input logic neg);
      rbst_pkg::coord_type r;
      if (neg) begin
         r = (q > QMAX_NEG) ? CMIN : rbst_pkg::coord_type'(~q[W-1:0] + W'(1));
      end else begin
         r = (q > QMAX_POS) ? CMAX : rbst_pkg::coord_type'(q[W-1:0]);
      end
      return r;
   endfunction

   // sign, saturation and unbounded slab
   always_comb begin
      if (flags_ff[NUM_W].dir_zero) begin
         slab_in.t_near = flags_ff[NUM_W].near_pos ? CMAX : CMIN;
         slab_in.t_far  = flags_ff[NUM_W].far_neg ? CMIN : CMAX;
      end else begin
         slab_in.t_near = sat_quo(quo_near, flags_ff[NUM_W].neg_near);
         slab_in.t_far  = sat_quo(quo_far, flags_ff[NUM_W].neg_far);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slab_ff <= slab_in;
      end
   end

   assign slab = slab_ff;

endmodule

### rtl/rbst_merge.sv
module rbst_merge #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  rbst_pkg::slab_type  slab [3],
   input  rbst_pkg::coord_type org [3],
   input  rbst_pkg::coord_type dir [3],
   output rbst_pkg::rsp_type   res
);

   localparam int W = rbst_pkg::COORD_W;
   localparam int PW = 2 * W;
   localparam logic signed [W:0] ONE_EXT = (W+1)'(1) << FRAC_BITS;
   localparam logic signed [PW:0] SMAX = {{(W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW:0] SMIN = {{(W+2){1'b1}}, {(W-1){1'b0}}};

   rbst_pkg::coord_type t1_min, t1_max, t2_min, t2_max;
   logic                miss1, miss2, hit_in;

   logic                hit_ff, hit2_ff;
   rbst_pkg::coord_type tmin_ff, tmin2_ff;
   rbst_pkg::coord_type org_ff [3];
   rbst_pkg::coord_type org2_ff [3];
   rbst_pkg::coord_type dir_ff [3];
   logic signed [PW-1:0] prod_ff [3];
   rbst_pkg::coord_type pos [3];
   rbst_pkg::rsp_type   res_ff;

   // interval intersection in x, y, z order
   always_comb begin
      miss1  = (slab[0].t_near > slab[1].t_far) || (slab[1].t_near > slab[0].t_far);
      t1_min = (slab[1].t_near > slab[0].t_near) ? slab[1].t_near : slab[0].t_near;
      t1_max = (slab[1].t_far < slab[0].t_far) ? slab[1].t_far : slab[0].t_far;
      miss2  = (t1_min > slab[2].t_far) || (slab[2].t_near > t1_max);
      t2_min = (slab[2].t_near > t1_min) ? slab[2].t_near : t1_min;
      t2_max = (slab[2].t_far < t1_max) ? slab[2].t_far : t1_max;
      hit_in = !miss1 && !miss2 && ($signed({t2_min[W-1], t2_min}) < ONE_EXT)
               && (t2_max > 0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_in;
         tmin_ff <= t2_min;
         org_ff  <= org;
         dir_ff  <= dir;
      end
   end

   // direction times entry parameter
   always_ff @(posedge clock) begin
      if (en) begin
         hit2_ff  <= hit_ff;
         tmin2_ff <= tmin_ff;
         org2_ff  <= org_ff;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= PW'(dir_ff[i]) * PW'(tmin_ff);
         end
      end
   end

   // scale toward zero, add origin, saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [PW-1:0] q;
         logic signed [PW:0]   sum;
         q = prod_ff[i] >>> FRAC_BITS;
         if (prod_ff[i][PW-1] && (prod_ff[i][FRAC_BITS-1:0] != '0)) begin
            q = q + PW'(1);
         end
         sum = {q[PW-1], q} + {{(W+1){org2_ff[i][W-1]}}, org2_ff[i]};
         if (sum > SMAX) begin
            pos[i] = SMAX[W-1:0];
         end else if (sum < SMIN) begin
            pos[i] = SMIN[W-1:0];
         end else begin
            pos[i] = sum[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.hit        <= hit2_ff;
         res_ff.entry_dist <= hit2_ff ? tmin2_ff : '0;
         res_ff.hit_pos_x  <= hit2_ff ? pos[0] : '0;
         res_ff.hit_pos_y  <= hit2_ff ? pos[1] : '0;
         res_ff.hit_pos_z  <= hit2_ff ? pos[2] : '0;
      end
   end

   assign res = res_ff;

endmodule

### rtl/ray_box_slab_test.sv
// throughput: one transaction per cycle while the output buffer has a free slot;
// set by the bit-per-stage dividers, six in parallel
// a two-entry output buffer keeps the pipeline moving while a response waits
// reset (synchronous, active high) empties the pipeline and buffer and clears the box to zero
module ray_box_slab_test #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rbst_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rbst_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rbst_pkg::ADDR_W-1:0]   paddr,
   input  logic [rbst_pkg::COORD_W-1:0]  pwdata,
   output logic [rbst_pkg::COORD_W-1:0]  prdata,
   output logic                          pready
);

   localparam int NUM_W = rbst_pkg::COORD_W + 1 + FRAC_BITS;
   localparam int LANE_LAT = NUM_W + 2;
   localparam int DEPTH = LANE_LAT + 3;

   rbst_pkg::coord_type box_ff [rbst_pkg::NUM_REGS];
   logic [rbst_pkg::IDX_W-1:0] reg_idx;

   logic                en;
   logic                vld_ff [DEPTH];
   rbst_pkg::coord_type org_ff [LANE_LAT][3];
   rbst_pkg::coord_type dir_ff [LANE_LAT][3];
   rbst_pkg::slab_type  slab [3];
   rbst_pkg::rsp_type   res;

   rbst_pkg::rsp_type   slot_ff [2];
   rbst_pkg::rsp_type   slot_in [2];
   logic [1:0]          count_ff, count_in;
   logic                push, pop;

   // register file
   assign reg_idx = paddr[rbst_pkg::ADDR_W-1:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rbst_pkg::NUM_REGS; i++) begin
            box_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            rbst_pkg::REG_BOX_MIN_X: box_ff[0] <= pwdata;
            rbst_pkg::REG_BOX_MIN_Y: box_ff[1] <= pwdata;
            rbst_pkg::REG_BOX_MIN_Z: box_ff[2] <= pwdata;
            rbst_pkg::REG_BOX_MAX_X: box_ff[3] <= pwdata;
            rbst_pkg::REG_BOX_MAX_Y: box_ff[4] <= pwdata;
            rbst_pkg::REG_BOX_MAX_Z: box_ff[5] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rbst_pkg::REG_BOX_MIN_X: prdata = box_ff[0];
         rbst_pkg::REG_BOX_MIN_Y: prdata = box_ff[1];
         rbst_pkg::REG_BOX_MIN_Z: prdata = box_ff[2];
         rbst_pkg::REG_BOX_MAX_X: prdata = box_ff[3];
         rbst_pkg::REG_BOX_MAX_Y: prdata = box_ff[4];
         rbst_pkg::REG_BOX_MAX_Z: prdata = box_ff[5];
         default:                 prdata = '0;
      endcase
   end

   // pipeline moves whenever the output buffer has a free slot
   assign en        = (count_ff != 2'd2);
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < DEPTH; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // origin and direction delayed to meet the lane results
   always_ff @(posedge clock) begin
      if (en) begin
         org_ff[0][0] <= req_data.origin_x;
         org_ff[0][1] <= req_data.origin_y;
         org_ff[0][2] <= req_data.origin_z;
         dir_ff[0][0] <= req_data.dir_x;
         dir_ff[0][1] <= req_data.dir_y;
         dir_ff[0][2] <= req_data.dir_z;
         for (int s = 1; s < LANE_LAT; s++) begin
            org_ff[s] <= org_ff[s-1];
            dir_ff[s] <= dir_ff[s-1];
         end
      end
   end

   rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock  (clock),
      .en     (en),
      .box_lo (box_ff[0]),
      .box_hi (box_ff[3]),
      .org    (req_data.origin_x),
      .dir    (req_data.dir_x),
      .slab   (slab[0])
   );

   rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock  (clock),
      .en     (en),
      .box_lo (box_ff[1]),
      .box_hi (box_ff[4]),
      .org    (req_data.origin_y),
      .dir    (req_data.dir_y),
      .slab   (slab[1])
   );

   rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock  (clock),
      .en     (en),
      .box_lo (box_ff[2]),
      .box_hi (box_ff[5]),
      .org    (req_data.origin_z),
      .dir    (req_data.dir_z),
      .slab   (slab[2])
   );

   rbst_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock (clock),
      .en    (en),
      .slab  (slab),
      .org   (org_ff[LANE_LAT-1]),
      .dir   (dir_ff[LANE_LAT-1]),
      .res   (res)
   );

   // two-entry output buffer
   assign push = en && vld_ff[DEPTH-1];
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if ((count_ff - 2'(pop)) == 2'd0) begin
            slot_in[0] = res;
         end else begin
            slot_in[1] = res;
         end
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[0];

endmodule

### rtl/rbst_checker.sv
module rbst_checker #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rbst_pkg::rsp_type rsp_data
);

   localparam int W = rbst_pkg::COORD_W;
   localparam logic signed [W:0] ONE_EXT = (W+1)'(1) << FRAC_BITS;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response right after reset");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a miss carries all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.entry_dist == '0
         && rsp_data.hit_pos_x == '0 && rsp_data.hit_pos_y == '0
         && rsp_data.hit_pos_z == '0)
      else $error("miss with nonzero payload");

   // a hit enters before the segment end
   a_hit_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |->
         $signed({rsp_data.entry_dist[W-1], rsp_data.entry_dist}) < ONE_EXT)
      else $error("hit with entry beyond segment end");

endmodule

bind ray_box_slab_test rbst_checker #(.FRAC_BITS(FRAC_BITS)) u_rbst_checker (.*);
